// ===== src/swtt_pkg.sv =====
// shared types and constants for the sleep wakeup timer table
`default_nettype none

package swtt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int MAX_OUT     = 16;

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int OIDX_W = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
   localparam int OUT_W  = $clog2(MAX_OUT + 1);

   localparam int ID_W   = 8;
   localparam int TICK_W = 63;
   localparam int KIND_W = 3;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   localparam logic MODE_SLEEP = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [KIND_W-1:0] KIND_QUEUED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WOKEN   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NONE    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FULL    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_IDLE    = 3'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_IDLE_ID = 3'd0;

   typedef struct packed {
      logic              mode;
      logic [ID_W-1:0]   thread_id;
      logic [TICK_W-1:0] tick_value;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ID_W-1:0]   woken_id;
      logic [TICK_W-1:0] next_wake;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] wake;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

`default_nettype wire

// ===== src/sleep_wakeup_timer_table.sv =====
// sleep wakeup timer table: sleeping thread slots held in ram, scanned on each tick
//
//   channel   ports                          handshake
//   request   start, busy, req_data          word taken when start and not busy
//   response  rsp_valid, rsp_data            one word per cycle, strobe only
//   csr       psel, penable, pwrite, paddr   apb write, pready tied high
//
// a sleep word leaves the block idle; its response is registered and follows on the next cycle
// a tick word scans the slot ram (one slot per cycle, set by the single read port),
// then sends its responses: one per woken thread, or a single none word if none woke
// reset clears the slot count and idle_id and sets the earliest wake to TICK_MAX; slot ram needs no clearing
// responses cannot be held off
`default_nettype none

module sleep_wakeup_timer_table (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire swtt_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   output swtt_pkg::rsp_type                        rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [swtt_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [swtt_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [swtt_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready
);

   import swtt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [TICK_W-1:0] earliest_ff, earliest_in;
   logic [ID_W-1:0]   idle_id_ff, idle_id_in;
   logic [TICK_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0]  rd_ff, rd_in;
   logic              pend_ff, pend_in;
   logic [CNT_W-1:0]  wr_ff, wr_in;
   logic [TICK_W-1:0] min_ff, min_in;
   logic [OUT_W-1:0]  n_ff, n_in;
   logic [OUT_W-1:0]  k_ff, k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic [ID_W-1:0]   woke_ff [MAX_OUT];

   logic              woke_we;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   slot_type          mem_wdata;
   logic              mem_re;
   slot_type          mem_rdata;
   logic [SLOT_W-1:0] mem_rbits;
   logic              accept;
   logic              csr_write;
   logic              last_word;

   swtt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (rd_ff[IDX_W-1:0]),
      .rd_data (mem_rbits)
   );

   assign mem_rdata = slot_type'(mem_rbits);
   assign accept    = start && (state_ff == ST_IDLE);
   assign csr_write = psel && penable && pwrite;
   assign last_word = ((k_ff + OUT_W'(1)) == n_ff);

   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      earliest_in  = earliest_ff;
      idle_id_in   = idle_id_ff;
      now_in       = now_ff;
      rd_in        = rd_ff;
      pend_in      = pend_ff;
      wr_in        = wr_ff;
      min_in       = min_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      woke_we      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = used_ff[IDX_W-1:0];
      mem_wdata    = '{id: req_data.thread_id, wake: req_data.tick_value};
      mem_re       = 1'b0;

      if (csr_write && (paddr[2] == CSR_IDLE_ID[2])) begin
         idle_id_in = pwdata[ID_W-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.mode == MODE_SLEEP) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{kind: KIND_QUEUED, woken_id: '0,
                                   next_wake: earliest_ff, last: 1'b1};
                  if (req_data.thread_id == idle_id_ff) begin
                     rsp_in.kind = KIND_IDLE;
                  end else if (used_ff >= CNT_W'(TABLE_DEPTH)) begin
                     rsp_in.kind = KIND_FULL;
                  end else begin
                     mem_we  = 1'b1;
                     used_in = used_ff + CNT_W'(1);
                     if (req_data.tick_value < earliest_ff) begin
                        earliest_in       = req_data.tick_value;
                        rsp_in.next_wake  = req_data.tick_value;
                     end
                  end
               end else begin
                  now_in   = req_data.tick_value;
                  rd_in    = '0;
                  pend_in  = 1'b0;
                  wr_in    = '0;
                  min_in   = TICK_MAX;
                  n_in     = '0;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_ff < used_ff) begin
               mem_re  = 1'b1;
               rd_in   = rd_ff + CNT_W'(1);
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if ((now_ff >= mem_rdata.wake) && (n_ff < OUT_W'(MAX_OUT))) begin
                  woke_we = 1'b1;
                  n_in    = n_ff + OUT_W'(1);
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = wr_ff[IDX_W-1:0];
                  mem_wdata = mem_rdata;
                  wr_in     = wr_ff + CNT_W'(1);
                  if (mem_rdata.wake < min_ff) begin
                     min_in = mem_rdata.wake;
                  end
               end
            end else if (rd_ff >= used_ff) begin
               used_in     = wr_ff;
               earliest_in = min_ff;
               k_in        = '0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            if (n_ff == '0) begin
               rsp_in   = '{kind: KIND_NONE, woken_id: '0,
                            next_wake: earliest_ff, last: 1'b1};
               state_in = ST_IDLE;
            end else begin
               rsp_in = '{kind: KIND_WOKEN, woken_id: woke_ff[k_ff[OIDX_W-1:0]],
                          next_wake: earliest_ff, last: last_word};
               k_in   = k_ff + OUT_W'(1);
               if (last_word) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         earliest_ff  <= TICK_MAX;
         idle_id_ff   <= '0;
         rd_ff        <= '0;
         pend_ff      <= 1'b0;
         wr_ff        <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         earliest_ff  <= earliest_in;
         idle_id_ff   <= idle_id_in;
         rd_ff        <= rd_in;
         pend_ff      <= pend_in;
         wr_ff        <= wr_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff <= now_in;
      min_ff <= min_in;
      rsp_ff <= rsp_in;
      if (woke_we) begin
         woke_ff[n_ff[OIDX_W-1:0]] <= mem_rdata.id;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_IDLE_ID[2]) ?
                      {{(CSR_DATA_W-ID_W){1'b0}}, idle_id_ff} : '0;

endmodule

`default_nettype wire

// ===== src/swtt_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module swtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sim/swtt_alarm_checker.sv =====
// checker for the sleep wakeup timer table: predicts wake reports and compares responses
`timescale 1ns / 100ps

module swtt_alarm_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  swtt_pkg::req_type                    req_data,
   input  logic                                 rsp_valid,
   input  swtt_pkg::rsp_type                    rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic                                 pready,
   input  logic [swtt_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [swtt_pkg::CSR_DATA_W-1:0]      pwdata,
   output int                                   mismatch_count,
   output int                                   awaited_count
);
   import swtt_pkg::*;

   logic [ID_W-1:0]   sleeper_id [TABLE_DEPTH];
   logic [TICK_W-1:0] sleeper_wake [TABLE_DEPTH];
   int                sleeper_count;
   logic [TICK_W-1:0] soonest_wake;
   logic [ID_W-1:0]   resting_id;
   rsp_type           alarm_queue [$];

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
      sleeper_count  = 0;
      soonest_wake   = TICK_MAX;
      resting_id     = '0;
   end

   function automatic rsp_type alarm_word(input logic [KIND_W-1:0] kind,
                                          input logic [ID_W-1:0] id,
                                          input logic [TICK_W-1:0] nw,
                                          input logic fin);
      rsp_type w;
      w.kind      = kind;
      w.woken_id  = id;
      w.next_wake = nw;
      w.last      = fin;
      return w;
   endfunction

   task automatic predict_alarms(input req_type w);
      logic [ID_W-1:0]   woke [MAX_OUT];
      int                n;
      int                kept;
      logic [TICK_W-1:0] lowest;
      n      = 0;
      kept   = 0;
      lowest = TICK_MAX;
      if (w.mode == MODE_SLEEP) begin
         if (w.thread_id == resting_id) begin
            alarm_queue.push_back(alarm_word(KIND_IDLE, '0, soonest_wake, 1'b1));
         end else if (sleeper_count >= TABLE_DEPTH) begin
            alarm_queue.push_back(alarm_word(KIND_FULL, '0, soonest_wake, 1'b1));
         end else begin
            sleeper_id[sleeper_count]   = w.thread_id;
            sleeper_wake[sleeper_count] = w.tick_value;
            sleeper_count++;
            if (w.tick_value < soonest_wake) begin
               soonest_wake = w.tick_value;
            end
            alarm_queue.push_back(alarm_word(KIND_QUEUED, '0, soonest_wake, 1'b1));
         end
      end else begin
         // due entries leave in arrival order, the rest are compacted
         for (int r = 0; r < sleeper_count; r++) begin
            if (w.tick_value >= sleeper_wake[r] && n < MAX_OUT) begin
               woke[n] = sleeper_id[r];
               n++;
            end else begin
               sleeper_id[kept]   = sleeper_id[r];
               sleeper_wake[kept] = sleeper_wake[r];
               if (sleeper_wake[kept] < lowest) begin
                  lowest = sleeper_wake[kept];
               end
               kept++;
            end
         end
         sleeper_count = kept;
         soonest_wake  = lowest;
         if (n == 0) begin
            alarm_queue.push_back(alarm_word(KIND_NONE, '0, soonest_wake, 1'b1));
         end else begin
            for (int k = 0; k < n; k++) begin
               alarm_queue.push_back(alarm_word(KIND_WOKEN, woke[k], soonest_wake,
                                                k == n - 1));
            end
         end
      end
   endtask

   task automatic compare_alarm(input rsp_type got);
      rsp_type want;
      if (alarm_queue.size() == 0) begin
         $error("response word with nothing expected: kind %0d woken_id %0d",
                got.kind, got.woken_id);
         mismatch_count++;
      end else begin
         want = alarm_queue.pop_front();
         if (got.kind !== want.kind) begin
            $error("kind: expected %0d actual %0d", want.kind, got.kind);
            mismatch_count++;
         end
         if (got.woken_id !== want.woken_id) begin
            $error("woken_id: expected %0d actual %0d", want.woken_id, got.woken_id);
            mismatch_count++;
         end
         if (got.next_wake !== want.next_wake) begin
            $error("next_wake: expected %0h actual %0h", want.next_wake, got.next_wake);
            mismatch_count++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d actual %0d", want.last, got.last);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sleeper_count = 0;
         soonest_wake  = TICK_MAX;
         resting_id    = '0;
         alarm_queue.delete();
      end else begin
         if (rsp_valid) begin
            compare_alarm(rsp_data);
         end
         if (start && !busy) begin
            predict_alarms(req_data);
         end
         if (psel && penable && pwrite && pready && paddr[2] == CSR_IDLE_ID[2]) begin
            resting_id = pwdata[ID_W-1:0];
         end
      end
      awaited_count = alarm_queue.size();
   end

endmodule

// ===== sim/sleep_wakeup_timer_table_tb.sv =====
// testbench top for the sleep wakeup timer table: stimulus, idling phases and verdict
`timescale 1ns / 100ps

module sleep_wakeup_timer_table_tb;
   import swtt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_WORDS  = 80;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int mismatch_count;
   int awaited_count;
   int idle_pct;
   int cycle_count;

   sleep_wakeup_timer_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   swtt_alarm_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [TICK_W-1:0] any_tick();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[TICK_W-1:0];
   endfunction

   // sender gap, then hold the word until the block takes it
   task automatic send_word(input logic mode, input logic [ID_W-1:0] id,
                            input logic [TICK_W-1:0] tv);
      req_type w;
      w.mode       = mode;
      w.thread_id  = id;
      w.tick_value = tv;
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic wait_quiet;
      start <= 1'b0;
      @(negedge clock);
      while (awaited_count != 0 || busy) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      logic [ID_W-1:0]   idle_val;
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] now;
      logic [TICK_W-1:0] tv;
      int                sleep_pct;
      int                roll;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      psel     = 1'b0;
      penable  = 1'b0;
      pwrite   = 1'b0;
      paddr    = '0;
      pwdata   = '0;
      idle_pct = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words
      send_word(MODE_SLEEP, 8'd0, 63'd5);
      send_word(MODE_TICK, 8'hff, 63'd0);
      send_word(MODE_SLEEP, 8'hff, TICK_MAX);
      send_word(MODE_SLEEP, 8'd7, 63'd100);
      send_word(MODE_SLEEP, 8'd7, 63'd50);
      send_word(MODE_TICK, 8'h55, 63'd49);
      send_word(MODE_TICK, 8'haa, 63'd100);
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         send_word(MODE_SLEEP, ID_W'(i), TICK_W'((i - 1) * 10));
      end
      send_word(MODE_SLEEP, 8'haa, 63'd1);
      send_word(MODE_TICK, 8'd0, 63'd75);
      send_word(MODE_TICK, 8'd0, TICK_MAX);
      wait_quiet;
      csr_write(CSR_IDLE_ID, 32'd255);
      send_word(MODE_SLEEP, 8'hff, 63'd0);
      send_word(MODE_SLEEP, 8'd0, 63'd0);
      send_word(MODE_TICK, 8'd0, 63'd0);

      // random phases with differing idle rates and idle ids
      for (int ph = 0; ph < 4; ph++) begin
         wait_quiet;
         case (ph)
            0: begin
               idle_val  = 8'd0;
               idle_pct  = 0;
               sleep_pct = 55;
               now       = '0;
            end
            1: begin
               idle_val  = 8'hff;
               idle_pct  = 86;
               sleep_pct = 60;
               now       = TICK_MAX - 63'd5000;
            end
            2: begin
               idle_val  = ID_W'($urandom);
               idle_pct  = 0;
               sleep_pct = 80;
               now       = any_tick();
            end
            default: begin
               idle_val  = ID_W'($urandom);
               idle_pct  = 35;
               sleep_pct = 50;
               now       = any_tick();
            end
         endcase
         csr_write(CSR_IDLE_ID, CSR_DATA_W'(idle_val));
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (ph == 1 && k == PHASE_WORDS / 2) begin
               wait_quiet;
            end
            roll = $urandom_range(0, 99);
            if (roll < sleep_pct) begin
               id = ID_W'($urandom);
               if ($urandom_range(0, 15) == 0) begin
                  id = idle_val;
               end
               if ($urandom_range(0, 9) == 0) begin
                  tv = any_tick();
               end else begin
                  tv = now + TICK_W'($urandom_range(0, 300));
               end
               send_word(MODE_SLEEP, id, tv);
            end else begin
               if ($urandom_range(0, 9) == 0) begin
                  tv = any_tick();
               end else begin
                  now = now + TICK_W'($urandom_range(0, 120));
                  tv  = now;
               end
               send_word(MODE_TICK, ID_W'($urandom), tv);
            end
         end
      end

      wait_quiet;
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
